### sv/kle_pkg.sv
`timescale 1ns / 1ps

package kle_pkg;

  localparam int LINE_CHARS = 16;

  localparam int CURSOR_W = $clog2(LINE_CHARS);
  localparam int COUNT_W  = $clog2(LINE_CHARS + 1);
  localparam int IDX_W    = $clog2(LINE_CHARS + 2);

  localparam int KEY_W    = 8;
  localparam int DATA_W   = 8;
  localparam int POS_W    = 5;
  localparam int CUR_W    = 4;
  localparam int LEN_W    = 5;
  localparam int CODE_W   = 10;
  localparam int DIGIT_W  = 2;

  localparam logic [DATA_W-1:0]  ADDR_RESET = 8'h10;
  localparam logic [CODE_W-1:0]  CODE_MIN   = 10'd33;
  localparam logic [CODE_W-1:0]  CODE_MAX   = 10'd254;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 2'd3;

  localparam logic [KEY_W-1:0] KEY_NONE   = 8'h00;
  localparam logic [KEY_W-1:0] KEY_LEFT   = 8'h2F;
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'h58;
  localparam logic [KEY_W-1:0] KEY_DELETE = 8'h43;
  localparam logic [KEY_W-1:0] KEY_CODE   = 8'h2B;
  localparam logic [KEY_W-1:0] KEY_ENTER  = 8'h3D;
  localparam logic [KEY_W-1:0] KEY_SEND   = 8'h2D;
  localparam logic [KEY_W-1:0] KEY_0      = 8'h30;
  localparam logic [KEY_W-1:0] KEY_9      = 8'h39;

  localparam logic KIND_DISPLAY = 1'b0;
  localparam logic KIND_BUS     = 1'b1;

  typedef struct packed {
    logic start;
    logic edit;
    logic emit;
    logic clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic key_none;
    logic key_send;
    logic line_empty;
    logic slot_free;
    logic item_last;
    logic send_run;
  } dp_stat_t;

endpackage

### sv/kle_ctrl.sv
`timescale 1ns / 1ps

module kle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kle_pkg::dp_stat_t stat,
  output kle_pkg::ctl_cmd_t cmd
);
  import kle_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  logic [0:0] state_r;
  logic [0:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !stat.key_none && !(stat.key_send && stat.line_empty)) begin
          cmd.start = 1'b1;
          cmd.edit  = !stat.key_send;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          if (stat.item_last) begin
            cmd.clear = stat.send_run;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/kle_datapath.sv
`timescale 1ns / 1ps

module kle_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [kle_pkg::DATA_W-1:0]   cfg_wr_data,
  input  logic [kle_pkg::KEY_W-1:0]    in_key_code,
  input  logic                         out_stall,
  input  kle_pkg::ctl_cmd_t            cmd,
  output kle_pkg::dp_stat_t            stat,
  output logic                         out_valid,
  output logic                         out_kind,
  output logic [kle_pkg::DATA_W-1:0]   out_data_byte,
  output logic [kle_pkg::POS_W-1:0]    out_position,
  output logic [kle_pkg::CUR_W-1:0]    out_cursor,
  output logic [kle_pkg::LEN_W-1:0]    out_length,
  output logic                         out_entry_mode,
  output logic                         out_last
);
  import kle_pkg::*;

  logic [DATA_W-1:0]   dest_r;
  logic [DATA_W-1:0]   line_r   [LINE_CHARS];
  logic [DATA_W-1:0]   line_nxt [LINE_CHARS];
  logic [DATA_W-1:0]   line_up  [LINE_CHARS];
  logic [DATA_W-1:0]   line_dn  [LINE_CHARS];
  logic [CURSOR_W-1:0] cursor_r;
  logic [COUNT_W-1:0]  total_r;
  logic                mode_r;
  logic [DIGIT_W-1:0]  digits_r;
  logic [CODE_W-1:0]   code_r;
  logic [IDX_W-1:0]    idx_r;
  logic                send_r;
  logic                out_valid_r;
  logic                out_valid_nxt;

  logic                out_kind_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [CUR_W-1:0]    out_cursor_r;
  logic [LEN_W-1:0]    out_length_r;
  logic                out_mode_r;
  logic                out_last_r;

  logic                ins_en;
  logic                del_en;
  logic [DATA_W-1:0]   ins_char;
  logic [CURSOR_W-1:0] cursor_ed;
  logic [COUNT_W-1:0]  total_ed;
  logic                mode_ed;
  logic [DIGIT_W-1:0]  digits_ed;
  logic [CODE_W-1:0]   code_ed;
  logic [CODE_W-1:0]   code_x10;

  logic [IDX_W-1:0]    rd_sel;
  logic [DATA_W-1:0]   rd_data;
  logic [IDX_W-1:0]    total_ext;
  logic                item_last;
  logic [DATA_W-1:0]   item_data;
  logic [CUR_W-1:0]    item_cursor;
  logic [LEN_W-1:0]    item_length;

  // key decode and edit of the scalar state
  assign code_x10 = (code_r << 3) + (code_r << 1);

  always_comb begin
    ins_en    = 1'b0;
    del_en    = 1'b0;
    ins_char  = in_key_code;
    cursor_ed = cursor_r;
    total_ed  = total_r;
    mode_ed   = mode_r;
    digits_ed = digits_r;
    code_ed   = code_r;
    if (mode_r) begin
      if (in_key_code == KEY_ENTER) begin
        if (digits_r != '0 && code_r >= CODE_MIN && code_r <= CODE_MAX &&
            total_r < COUNT_W'(LINE_CHARS)) begin
          ins_en   = 1'b1;
          ins_char = code_r[DATA_W-1:0];
        end
        mode_ed   = 1'b0;
        digits_ed = '0;
        code_ed   = '0;
      end else if (in_key_code inside {[KEY_0:KEY_9]} && digits_r < DIGIT_MAX) begin
        code_ed   = code_x10 + CODE_W'(in_key_code[3:0]);
        digits_ed = digits_r + 1'b1;
      end
    end else begin
      case (in_key_code)
        KEY_CODE: begin
          mode_ed   = 1'b1;
          digits_ed = '0;
          code_ed   = '0;
        end
        KEY_LEFT: begin
          if (cursor_r != '0) cursor_ed = cursor_r - 1'b1;
        end
        KEY_RIGHT: begin
          if (COUNT_W'(cursor_r) < total_r && cursor_r < CURSOR_W'(LINE_CHARS - 1))
            cursor_ed = cursor_r + 1'b1;
        end
        KEY_DELETE: begin
          if (COUNT_W'(cursor_r) < total_r) del_en = 1'b1;
        end
        default: begin
          if (total_r < COUNT_W'(LINE_CHARS - 1)) ins_en = 1'b1;
        end
      endcase
    end
    if (ins_en) begin
      total_ed = total_r + 1'b1;
      if (cursor_r < CURSOR_W'(LINE_CHARS - 1)) cursor_ed = cursor_r + 1'b1;
    end
    if (del_en) total_ed = total_r - 1'b1;
  end

  // line buffer: each cell takes its own neighbour on insert or delete
  always_comb begin
    line_up[0]            = '0;
    line_dn[LINE_CHARS-1] = '0;
    for (int j = 1; j < LINE_CHARS; j++) begin
      line_up[j]   = line_r[j-1];
      line_dn[j-1] = line_r[j];
    end
  end

  always_comb begin
    for (int j = 0; j < LINE_CHARS; j++) begin
      line_nxt[j] = line_r[j];
      if (cmd.clear) begin
        line_nxt[j] = '0;
      end else if (cmd.edit && ins_en) begin
        if (COUNT_W'(j) == COUNT_W'(cursor_r)) begin
          line_nxt[j] = ins_char;
        end else if (COUNT_W'(j) > COUNT_W'(cursor_r) && COUNT_W'(j) <= total_r) begin
          line_nxt[j] = line_up[j];
        end
      end else if (cmd.edit && del_en) begin
        if (COUNT_W'(j) >= COUNT_W'(cursor_r) && COUNT_W'(j) < total_r) begin
          line_nxt[j] = (COUNT_W'(j + 1) < total_r) ? line_dn[j] : '0;
        end
      end
    end
  end

  // next item of the current run
  assign total_ext = IDX_W'(total_r);
  assign rd_sel    = send_r ? idx_r - 1'b1 : idx_r;
  assign rd_data   = line_r[rd_sel[CURSOR_W-1:0]];

  always_comb begin
    if (send_r) begin
      item_last   = (idx_r == total_ext + 1'b1);
      item_data   = (idx_r == '0) ? dest_r : (item_last ? '0 : rd_data);
      item_cursor = '0;
      item_length = '0;
    end else begin
      item_last   = (total_r == '0) || (idx_r + 1'b1 == total_ext);
      item_data   = (total_r == '0) ? '0 : rd_data;
      item_cursor = CUR_W'(cursor_r);
      item_length = LEN_W'(total_r);
    end
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && out_stall);

  always_comb begin
    stat            = '0;
    stat.key_none   = (in_key_code == KEY_NONE);
    stat.key_send   = (in_key_code == KEY_SEND);
    stat.line_empty = (total_r == '0);
    stat.slot_free  = !out_valid_r || !out_stall;
    stat.item_last  = item_last;
    stat.send_run   = send_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r      <= ADDR_RESET;
      for (int j = 0; j < LINE_CHARS; j++) line_r[j] <= '0;
      cursor_r    <= '0;
      total_r     <= '0;
      mode_r      <= 1'b0;
      digits_r    <= '0;
      code_r      <= '0;
      idx_r       <= '0;
      send_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) dest_r <= cfg_wr_data;
      line_r <= line_nxt;
      if (cmd.edit) begin
        cursor_r <= cursor_ed;
        total_r  <= total_ed;
        mode_r   <= mode_ed;
        digits_r <= digits_ed;
        code_r   <= code_ed;
      end
      if (cmd.clear) begin
        cursor_r <= '0;
        total_r  <= '0;
      end
      if (cmd.start) begin
        idx_r  <= '0;
        send_r <= stat.key_send;
      end else if (cmd.emit) begin
        idx_r <= idx_r + 1'b1;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r   <= send_r ? KIND_BUS : KIND_DISPLAY;
      out_data_r   <= item_data;
      out_pos_r    <= POS_W'(idx_r);
      out_cursor_r <= item_cursor;
      out_length_r <= item_length;
      out_mode_r   <= mode_r;
      out_last_r   <= item_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_data_byte  = out_data_r;
  assign out_position   = out_pos_r;
  assign out_cursor     = out_cursor_r;
  assign out_length     = out_length_r;
  assign out_entry_mode = out_mode_r;
  assign out_last       = out_last_r;

endmodule

### sv/keypad_line_editor.sv
`timescale 1ns / 1ps
// Keypad line editor.
// Input channel (in_valid/in_stall, in_key_code): one key per item. Key 0 is
// swallowed without output. Config: cfg_wr_en/cfg_wr_data set the bus address
// byte (reset 0x10); write it only while the block is idle.
// Output channel (out_valid/out_stall): after an editing key, one display item
// per character of the line (one item with data 0 for an empty line); after
// '-' on a non-empty line, a bus frame of address, characters and a null, then
// the line and cursor clear. out_last marks the final item of each key.
// Timing: a key is taken while in_stall is low; the controller then enters its
// run state and emits the key's items (1..18 of them) into the output register,
// one item per cycle while out_stall is low. The rate is set by
// the emit sequencer, which loads one item per cycle into the single output
// register; in_stall is high for the whole of a key's run and a stalled
// output simply holds the sequencer.
// Reset (rst_n low, synchronous) clears the line, cursor, code entry and any
// pending output; the address byte returns to 0x10.
module keypad_line_editor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [kle_pkg::DATA_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kle_pkg::KEY_W-1:0]  in_key_code,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_kind,
  output logic [kle_pkg::DATA_W-1:0] out_data_byte,
  output logic [kle_pkg::POS_W-1:0]  out_position,
  output logic [kle_pkg::CUR_W-1:0]  out_cursor,
  output logic [kle_pkg::LEN_W-1:0]  out_length,
  output logic                       out_entry_mode,
  output logic                       out_last
);
  import kle_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  kle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  kle_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_key_code    (in_key_code),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_position   (out_position),
    .out_cursor     (out_cursor),
    .out_length     (out_length),
    .out_entry_mode (out_entry_mode),
    .out_last       (out_last)
  );

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> stat.line_empty)
    else $error("line not empty after send");

  a_no_key_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_key_code == KEY_NONE) |=> !in_stall)
    else $error("empty key started a run");

  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor <= out_length)
    else $error("cursor beyond line length");

  a_display_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DISPLAY) |->
      (out_position < out_length || (out_length == '0 && out_position == '0)))
    else $error("display item outside line");

endmodule

### tb/sv/keypad_line_editor_test.sv
`timescale 1ns / 1ps

module keypad_line_editor_test;
  import kle_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int KEYS_PER_PHASE = 100;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [CUR_W-1:0]  cur;
    logic [LEN_W-1:0]  len;
    logic              mode;
    logic              last;
  } line_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [DATA_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KEY_W-1:0]  in_key_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_kind;
  logic [DATA_W-1:0] out_data_byte;
  logic [POS_W-1:0]  out_position;
  logic [CUR_W-1:0]  out_cursor;
  logic [LEN_W-1:0]  out_length;
  logic              out_entry_mode;
  logic              out_last;

  // editor state as predicted
  logic [DATA_W-1:0] line_buf [LINE_CHARS];
  int                cur_pos;
  int                line_len;
  logic              in_code;
  int                n_digits;
  int                code_acc;
  logic [DATA_W-1:0] bus_addr;

  logic [KEY_W-1:0]  pending_keys [$];
  line_item_t        expected_items [$];
  int                keys_queued;
  int                fail_count;
  bit                idle_on;
  int                gap_left;
  int                stall_left;
  int                quiet_cycles;
  line_item_t        got_item;
  line_item_t        want_item;

  keypad_line_editor DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_code    (in_key_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_position   (out_position),
    .out_cursor     (out_cursor),
    .out_length     (out_length),
    .out_entry_mode (out_entry_mode),
    .out_last       (out_last)
  );

  always #1 clk = ~clk;

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  function automatic string show_item(input line_item_t it);
    return $sformatf("kind=%0d data=%02h pos=%0d cur=%0d len=%0d mode=%0d last=%0d",
                     it.kind, it.data, it.pos, it.cur, it.len, it.mode, it.last);
  endfunction

  function automatic void push_result(input logic kind, input logic [DATA_W-1:0] data,
                                      input int pos, input logic last);
    line_item_t it;
    it.kind = kind;
    it.data = data;
    it.pos  = pos[POS_W-1:0];
    it.cur  = cur_pos[CUR_W-1:0];
    it.len  = line_len[LEN_W-1:0];
    it.mode = in_code;
    it.last = last;
    expected_items.push_back(it);
  endfunction

  function automatic void insert_at_cursor(input logic [DATA_W-1:0] c);
    for (int i = line_len; i > cur_pos && i < LINE_CHARS; i--) line_buf[i] = line_buf[i-1];
    if (cur_pos < LINE_CHARS) line_buf[cur_pos] = c;
    line_len++;
    if (cur_pos < LINE_CHARS - 1) cur_pos++;
  endfunction

  function automatic void apply_key(input logic [KEY_W-1:0] key);
    logic [DATA_W-1:0] frame [LINE_CHARS];
    int n;
    if (key == KEY_NONE) return;
    if (key == KEY_SEND) begin
      if (line_len == 0) return;
      n = line_len;
      frame = line_buf;
      foreach (line_buf[i]) line_buf[i] = '0;
      line_len = 0;
      cur_pos = 0;
      push_result(KIND_BUS, bus_addr, 0, 1'b0);
      for (int i = 0; i < n && i < LINE_CHARS; i++) push_result(KIND_BUS, frame[i], i + 1, 1'b0);
      push_result(KIND_BUS, 8'h00, n + 1, 1'b1);
      return;
    end
    if (in_code) begin
      if (key == KEY_ENTER) begin
        if (n_digits > 0 && code_acc >= CODE_MIN && code_acc <= CODE_MAX &&
            line_len < LINE_CHARS) insert_at_cursor(code_acc[DATA_W-1:0]);
        in_code = 1'b0;
        n_digits = 0;
        code_acc = 0;
      end else if (key >= KEY_0 && key <= KEY_9 && n_digits < DIGIT_MAX) begin
        code_acc = (code_acc * 10 + (key - KEY_0)) & 'h3FF;
        n_digits++;
      end
    end else begin
      case (key)
        KEY_CODE: begin
          in_code = 1'b1;
          n_digits = 0;
          code_acc = 0;
        end
        KEY_LEFT: begin
          if (cur_pos > 0) cur_pos--;
        end
        KEY_RIGHT: begin
          if (cur_pos < line_len && cur_pos < LINE_CHARS - 1) cur_pos++;
        end
        KEY_DELETE: begin
          if (cur_pos < line_len) begin
            for (int i = cur_pos; i < line_len && i < LINE_CHARS; i++)
              line_buf[i] = (i + 1 < line_len) ? line_buf[i+1] : 8'h00;
            line_len--;
          end
        end
        default: begin
          if (line_len < LINE_CHARS - 1) insert_at_cursor(key);
        end
      endcase
    end
    if (line_len == 0) begin
      push_result(KIND_DISPLAY, 8'h00, 0, 1'b1);
    end else begin
      for (int i = 0; i < line_len && i < LINE_CHARS; i++)
        push_result(KIND_DISPLAY, line_buf[i], i, (i + 1 == line_len));
    end
  endfunction

  function automatic void queue_key(input logic [KEY_W-1:0] key);
    pending_keys.push_back(key);
    if (key != KEY_NONE) keys_queued++;
  endfunction

  function automatic logic [KEY_W-1:0] any_char();
    return KEY_W'($urandom_range(1, 255));
  endfunction

  // '+', digits (with leading zeros, missing or excess digits, noise), usually '='
  function automatic void queue_code_entry();
    int v;
    int nd;
    int min_nd;
    queue_key(KEY_CODE);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 32;
      2: v = 33;
      3: v = 254;
      4: v = 255;
      5: v = 999;
      6: v = $urandom_range(0, 999);
      default: v = $urandom_range(33, 254);
    endcase
    min_nd = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
    nd = $urandom_range(min_nd, 3);
    if ($urandom_range(0, 9) == 0) nd = 0;
    for (int i = nd - 1; i >= 0; i--) begin
      queue_key(KEY_W'(KEY_0 + (v / (10 ** i)) % 10));
      if ($urandom_range(0, 9) == 0) queue_key(any_char());
    end
    if ($urandom_range(0, 5) == 0) queue_key(KEY_W'(KEY_0 + $urandom_range(0, 9)));
    if ($urandom_range(0, 9) != 0) queue_key(KEY_ENTER);
  endfunction

  function automatic void queue_edit_burst();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      repeat ($urandom_range(1, 4)) queue_key(any_char());
    end else if (pick < 47) begin
      repeat ($urandom_range(1, 3)) queue_key(KEY_LEFT);
    end else if (pick < 55) begin
      repeat ($urandom_range(1, 3)) queue_key(KEY_RIGHT);
    end else if (pick < 63) begin
      repeat ($urandom_range(1, 2)) queue_key(KEY_DELETE);
    end else if (pick < 80) begin
      queue_code_entry();
    end else if (pick < 87) begin
      queue_key(KEY_SEND);
    end else if (pick < 90) begin
      queue_key(KEY_NONE);
    end else if (pick < 95) begin
      // fill the line to the brim, then try a code insert and run off the end
      repeat ($urandom_range(14, 17)) queue_key(any_char());
      queue_code_entry();
      repeat ($urandom_range(1, 4)) queue_key(KEY_RIGHT);
    end else begin
      queue_key(KEY_W'($urandom_range(0, 255)));
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_keys.size() != 0 || in_valid || expected_items.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    bus_addr = value;
  endtask

  task automatic run_random_phase(input logic [DATA_W-1:0] addr, input bit idling);
    int target;
    write_address(addr);
    idle_on = idling;
    target = keys_queued + KEYS_PER_PHASE;
    while (keys_queued < target) queue_edit_burst();
    wait_drained();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) apply_key(in_key_code);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_keys.size() > 0) begin
          in_valid    <= 1'b1;
          in_key_code <= pending_keys.pop_front();
          gap_left = idle_on ? $urandom_range(0, 3) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_item = '{out_kind, out_data_byte, out_position, out_cursor, out_length,
                     out_entry_mode, out_last};
        if (expected_items.size() == 0) begin
          note_failure({"unexpected item: ", show_item(got_item)});
        end else begin
          want_item = expected_items.pop_front();
          if (got_item !== want_item)
            note_failure({"mismatch: expected ", show_item(want_item),
                          " got ", show_item(got_item)});
        end
        stall_left = idle_on ? $urandom_range(0, 3) : 0;
      end else if (!out_valid && stall_left == 0 && idle_on) begin
        stall_left = $urandom_range(0, 1);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("keypad_line_editor_test NOT OK");
      $finish;
    end
  end

  initial begin
    foreach (line_buf[i]) line_buf[i] = '0;
    cur_pos = 0;
    line_len = 0;
    in_code = 1'b0;
    n_digits = 0;
    code_acc = 0;
    bus_addr = ADDR_RESET;
    keys_queued = 0;
    fail_count = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-line cases, edits, code entry edge cases, send
    queue_key(KEY_NONE);
    queue_key(KEY_SEND);
    queue_key(KEY_DELETE);
    queue_key(KEY_LEFT);
    queue_key(KEY_RIGHT);
    queue_key(8'h41);
    queue_key(8'hFF);
    queue_key(KEY_LEFT);
    queue_key(KEY_DELETE);
    queue_key(KEY_RIGHT);
    queue_key(KEY_CODE);
    repeat (4) queue_key(KEY_9);
    queue_key(KEY_CODE);
    queue_key(8'h41);
    queue_key(KEY_ENTER);
    queue_key(KEY_CODE);
    repeat (2) queue_key(KEY_W'(KEY_0 + 3));
    queue_key(KEY_ENTER);
    queue_key(KEY_CODE);
    queue_key(KEY_ENTER);
    queue_key(KEY_SEND);
    wait_drained();

    run_random_phase(8'h00, 1'b1);
    run_random_phase(8'hFF, 1'b0);
    run_random_phase(DATA_W'($urandom_range(0, 255)), 1'b1);
    run_random_phase(DATA_W'($urandom_range(0, 255)), 1'b1);

    if (expected_items.size() != 0)
      note_failure($sformatf("%0d expected items never arrived", expected_items.size()));
    if (fail_count == 0) begin
      $display("keypad_line_editor_test OK");
    end else begin
      $display("keypad_line_editor_test NOT OK");
    end
    $finish;
  end

endmodule
